// ===== src/dmdt_pkg.sv =====
// Package for the display mode to detailed timing descriptor block.
// Holds the timing constants, reciprocal multipliers and small helper functions.
// Depends on nothing; used by the top level, by its checker and by the bench.
package dmdt_pkg;

	// Active size and blanking limits.
	localparam logic [15:0] SIZE_LIMIT = 16'd4095;
	localparam logic [11:0] HBLANK_MIN = 12'd160;
	localparam logic [11:0] VBLANK_MIN = 12'd30;
	localparam logic [9:0]  HSYNC_MIN  = 10'd32;
	localparam logic [10:0] HFRONT_MIN = 11'd48;
	localparam logic [9:0]  HSYNC_FALLBACK  = 10'd32;
	localparam logic [10:0] HFRONT_FALLBACK = 11'd48;
	localparam logic [3:0]  VFRONT = 4'd3;
	localparam logic [3:0]  VSYNC  = 4'd5;
	localparam logic [7:0]  DTD_FLAGS = 8'h1E;

	// Reciprocal multipliers. x/5 = (x * RECIP_5) >> 18 is exact for x below 2^16,
	// x/3 = (x * RECIP_3) >> 17 likewise, and y/625 = (y * RECIP_625) >> 36 is exact
	// for y below 2^26.
	localparam logic [15:0] RECIP_5   = 16'hCCCD;
	localparam logic [15:0] RECIP_3   = 16'hAAAB;
	localparam logic [26:0] RECIP_625 = 27'd109951163;

	// Rounding offset for the 10 kHz unit and the first rounded sum whose
	// quotient by 10000 no longer fits in 16 bits.
	localparam logic [35:0] ROUND_HALF  = 36'd5000;
	localparam logic [35:0] UNITS_LIMIT = 36'd655360000;

	function automatic logic [12:0] round_up8(input logic [12:0] v);
		logic [12:0] s;
		s = v + 13'd7;
		return {s[12:3], 3'b000};
	endfunction

endpackage

// ===== src/display_mode_to_detailed_timing.sv =====
// Top level of the display mode to detailed timing descriptor block.
// Six-stage pipeline that turns width, height and refresh into an EDID descriptor.
// Depends on dmdt_pkg.
//
// This block takes one display mode per clock cycle and returns its 18-byte EDID
// detailed timing descriptor through the pipeline: a mode accepted at a rising
// edge (start high, busy low) shows its result on the output ports once it reaches
// the last stage register, marked by done for a single cycle.
// busy is always low, so a new mode may be offered in every cycle, and the
// results come back in the order the modes went in. The receiver cannot hold a
// result off, so it must take each one while done is high. The stage count is set by
// the multiplier chain: the divisions by 20, 100 and 3 are reciprocal
// multiplications, the pixel clock product of total width, height and refresh is
// split over two stages, and the rounding to 10 kHz units is one more reciprocal
// multiplication. A rejected mode (a zero input, a width or height above 4095, or
// a pixel clock that rounds to zero or to more than 65535 units) still produces
// one result, with descriptor_ok low and every other output field zero.
module display_mode_to_detailed_timing (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic [9:0]  refresh_hz,
	output logic        done,
	output logic        descriptor_ok,
	output logic [15:0] pixel_clock_units,
	output logic [63:0] bytes_zero_to_seven,
	output logic [63:0] bytes_eight_to_fifteen,
	output logic [15:0] bytes_sixteen_seventeen
);

	// The pipeline never stalls, so a mode is accepted whenever start is high.
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// ------------------------------------------------------------------
	// Stage 1: reject check on the raw inputs and the divisions by 20.
	// Dividing by 20 is a shift by two followed by an exact division by 5.
	// ------------------------------------------------------------------
	logic [29:0] w_prod, h_prod;
	logic        bad_in;

	assign w_prod = 30'(frame_width[15:2]) * 30'(dmdt_pkg::RECIP_5);
	assign h_prod = 30'(frame_height[15:2]) * 30'(dmdt_pkg::RECIP_5);

	// Only width and height can push the blanking above the limit, so checking
	// the active size is enough to cover the blanking as well.
	assign bad_in = (frame_width == 16'd0) || (frame_height == 16'd0) ||
		(refresh_hz == 10'd0) || (frame_width > dmdt_pkg::SIZE_LIMIT) ||
		(frame_height > dmdt_pkg::SIZE_LIMIT);

	logic        vld_s1, bad_s1;
	logic [11:0] w20_s1, h20_s1, w_s1, h_s1;
	logic [9:0]  r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1 <= bad_in;
		w20_s1 <= w_prod[29:18];
		h20_s1 <= h_prod[29:18];
		w_s1   <= frame_width[11:0];
		h_s1   <= frame_height[11:0];
		r_s1   <= refresh_hz;
	end

	// ------------------------------------------------------------------
	// Stage 2: horizontal and vertical blanking, and width / 100 taken as
	// (width / 20) / 5.
	// ------------------------------------------------------------------
	logic [12:0] w20_round;
	logic [11:0] hblank_c, vblank_c;
	logic [27:0] w100_prod;

	assign w20_round = dmdt_pkg::round_up8({1'b0, w20_s1});
	assign hblank_c  = (w20_round[11:0] > dmdt_pkg::HBLANK_MIN) ? w20_round[11:0]
		: dmdt_pkg::HBLANK_MIN;
	assign vblank_c  = (h20_s1 > dmdt_pkg::VBLANK_MIN) ? h20_s1 : dmdt_pkg::VBLANK_MIN;
	assign w100_prod = 28'(w20_s1) * 28'(dmdt_pkg::RECIP_5);

	logic        vld_s2, bad_s2;
	logic [11:0] w_s2, h_s2, hblank_s2, vblank_s2;
	logic [9:0]  r_s2, w100_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s2    <= bad_s1;
		w_s2      <= w_s1;
		h_s2      <= h_s1;
		r_s2      <= r_s1;
		hblank_s2 <= hblank_c;
		vblank_s2 <= vblank_c;
		w100_s2   <= w100_prod[27:18];
	end

	// ------------------------------------------------------------------
	// Stage 3: hblank / 3, the sync width, and the first half of the pixel
	// clock product (total width times total height).
	// ------------------------------------------------------------------
	logic [27:0] hthird_prod;
	logic [9:0]  hsync_max;
	logic [12:0] hsync_round, htotal, vtotal;
	logic [25:0] hv_prod;

	assign hthird_prod = 28'(hblank_s2) * 28'(dmdt_pkg::RECIP_3);
	assign hsync_max   = (w100_s2 > dmdt_pkg::HSYNC_MIN) ? w100_s2 : dmdt_pkg::HSYNC_MIN;
	assign hsync_round = dmdt_pkg::round_up8(13'(hsync_max));
	// Totals are only used for accepted modes, where both fit in 13 bits.
	assign htotal  = 13'(w_s2) + 13'(hblank_s2);
	assign vtotal  = 13'(h_s2) + 13'(vblank_s2);
	assign hv_prod = 26'(htotal) * 26'(vtotal);

	logic        vld_s3, bad_s3;
	logic [11:0] w_s3, h_s3, hblank_s3, vblank_s3;
	logic [9:0]  r_s3, hsync_s3;
	logic [10:0] hthird_s3;
	logic [25:0] hv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		bad_s3    <= bad_s2;
		w_s3      <= w_s2;
		h_s3      <= h_s2;
		r_s3      <= r_s2;
		hblank_s3 <= hblank_s2;
		vblank_s3 <= vblank_s2;
		hthird_s3 <= hthird_prod[27:17];
		hsync_s3  <= hsync_round[9:0];
		hv_s3     <= hv_prod;
	end

	// ------------------------------------------------------------------
	// Stage 4: front porch with the fallback to the minimum porch and sync
	// when they do not fit in the blank, and the refresh multiplication.
	// ------------------------------------------------------------------
	logic [10:0] hfront_max;
	logic [12:0] hfront_round;
	logic [10:0] hfront_c;
	logic        porch_overrun;
	logic [35:0] clk_prod;

	assign hfront_max   = (hthird_s3 > dmdt_pkg::HFRONT_MIN) ? hthird_s3
		: dmdt_pkg::HFRONT_MIN;
	assign hfront_round = dmdt_pkg::round_up8(13'(hfront_max));
	assign hfront_c     = hfront_round[10:0];
	assign porch_overrun = (13'(hfront_c) + 13'(hsync_s3)) >= 13'(hblank_s3);
	assign clk_prod     = 36'(hv_s3) * 36'(r_s3);

	logic        vld_s4, bad_s4;
	logic [11:0] w_s4, h_s4, hblank_s4, vblank_s4;
	logic [10:0] hfront_s4;
	logic [9:0]  hsync_s4;
	logic [35:0] clk_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		bad_s4    <= bad_s3;
		w_s4      <= w_s3;
		h_s4      <= h_s3;
		hblank_s4 <= hblank_s3;
		vblank_s4 <= vblank_s3;
		hfront_s4 <= porch_overrun ? dmdt_pkg::HFRONT_FALLBACK : hfront_c;
		hsync_s4  <= porch_overrun ? dmdt_pkg::HSYNC_FALLBACK : hsync_s3;
		clk_s4    <= clk_prod;
	end

	// ------------------------------------------------------------------
	// Stage 5: add half a unit and check the 16-bit range. Below the limit
	// the sum fits in 30 bits, so dividing by 10000 becomes a shift by four
	// and a division by 625 of a 26-bit value.
	// ------------------------------------------------------------------
	logic [35:0] clk_round;

	assign clk_round = clk_s4 + dmdt_pkg::ROUND_HALF;

	logic        vld_s5, bad_s5, ovf_s5;
	logic [11:0] w_s5, h_s5, hblank_s5, vblank_s5;
	logic [10:0] hfront_s5;
	logic [9:0]  hsync_s5;
	logic [25:0] quot16_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		bad_s5    <= bad_s4;
		ovf_s5    <= clk_round >= dmdt_pkg::UNITS_LIMIT;
		w_s5      <= w_s4;
		h_s5      <= h_s4;
		hblank_s5 <= hblank_s4;
		vblank_s5 <= vblank_s4;
		hfront_s5 <= hfront_s4;
		hsync_s5  <= hsync_s4;
		quot16_s5 <= clk_round[29:4];
	end

	// ------------------------------------------------------------------
	// Stage 6: pixel clock units, final accept decision and descriptor
	// assembly into the output registers.
	// ------------------------------------------------------------------
	logic [52:0] units_prod;
	logic [15:0] units_c;
	logic        ok_c;
	logic [63:0] lo_c, mid_c;

	assign units_prod = 53'(quot16_s5) * 53'(dmdt_pkg::RECIP_625);
	assign units_c    = units_prod[51:36];
	assign ok_c       = !bad_s5 && !ovf_s5 && (units_c != 16'd0);

	// Bytes 0 to 7: clock, active and blank sizes with their high nibbles.
	assign lo_c = {h_s5[11:8], vblank_s5[11:8], vblank_s5[7:0], h_s5[7:0],
		w_s5[11:8], hblank_s5[11:8], hblank_s5[7:0], w_s5[7:0], units_c};

	// Bytes 8 to 15: porch and sync, then zero image size and borders.
	assign mid_c = {32'd0, hfront_s5[9:8], hsync_s5[9:8], 4'd0,
		dmdt_pkg::VFRONT, dmdt_pkg::VSYNC, hsync_s5[7:0], hfront_s5[7:0]};

	logic        done_s6, ok_s6;
	logic [15:0] units_s6, hi_s6;
	logic [63:0] lo_s6, mid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		ok_s6    <= ok_c;
		units_s6 <= ok_c ? units_c : 16'd0;
		lo_s6    <= ok_c ? lo_c : 64'd0;
		mid_s6   <= ok_c ? mid_c : 64'd0;
		hi_s6    <= ok_c ? {dmdt_pkg::DTD_FLAGS, 8'd0} : 16'd0;
	end

	assign done                    = done_s6;
	assign descriptor_ok           = ok_s6;
	assign pixel_clock_units       = units_s6;
	assign bytes_zero_to_seven     = lo_s6;
	assign bytes_eight_to_fifteen  = mid_s6;
	assign bytes_sixteen_seventeen = hi_s6;

endmodule

// ===== src/dmdt_checker.sv =====
// Port-level checker for the display mode to detailed timing block, with its bind.
// Watches the fixed latency and the shape of accepted and rejected results.
// Depends on dmdt_pkg and on the top level display_mode_to_detailed_timing.
module dmdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] frame_width,
	input logic [15:0] frame_height,
	input logic [9:0]  refresh_hz,
	input logic        done,
	input logic        descriptor_ok,
	input logic [15:0] pixel_clock_units,
	input logic [63:0] bytes_zero_to_seven,
	input logic [63:0] bytes_eight_to_fifteen,
	input logic [15:0] bytes_sixteen_seventeen
);

	// Every accepted item returns its result after passing the pipeline, and nothing else does.
	a_latency_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted item did not produce a result after six cycles");

	a_latency_none: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##6 !done)
		else $error("result appeared without an accepted item");

	// A mode with a zero field is always rejected.
	a_zero_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (frame_width == 16'd0 || frame_height == 16'd0 ||
		refresh_hz == 10'd0)) |-> ##6 (done && !descriptor_ok))
		else $error("mode with a zero field was not rejected");

	// A rejected result carries an all-zero descriptor.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !descriptor_ok) |-> (pixel_clock_units == 16'd0 &&
		bytes_zero_to_seven == 64'd0 && bytes_eight_to_fifteen == 64'd0 &&
		bytes_sixteen_seventeen == 16'd0))
		else $error("rejected result carries a nonzero descriptor");

	// An accepted result repeats its clock in bytes 0 and 1 and ends in the flags byte.
	a_accept_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && descriptor_ok) |-> (pixel_clock_units != 16'd0 &&
		bytes_zero_to_seven[15:0] == pixel_clock_units &&
		bytes_sixteen_seventeen == {dmdt_pkg::DTD_FLAGS, 8'd0}))
		else $error("accepted descriptor has a malformed clock or flags field");

endmodule

bind display_mode_to_detailed_timing dmdt_checker u_dmdt_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking bench for display_mode_to_detailed_timing.
// Drives display modes with random gaps and predicts every descriptor.
// Each result is checked against that prediction. Depends on dmdt_pkg and the block's RTL.
module tb;

	// PIPE_DEPTH is the stage count of the block. The drain wait at the end outlasts
	// the pipeline with a margin, so a stray late result is still seen.
	localparam int unsigned PIPE_DEPTH = 6;
	localparam int unsigned DRAIN_CYCLES = 4 * PIPE_DEPTH;
	// Even if every one of the 1400 items waited out the longest gap, the run would
	// stay far below this bound.
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 1380;

	// One expected or observed descriptor, with the same fields as the result ports.
	typedef struct packed {
		logic        ok;
		logic [15:0] clock_units;
		logic [63:0] low_bytes;
		logic [63:0] mid_bytes;
		logic [15:0] high_bytes;
	} descriptor_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] frame_width;
	logic [15:0] frame_height;
	logic [9:0]  refresh_hz;
	logic        done;
	logic        descriptor_ok;
	logic [15:0] pixel_clock_units;
	logic [63:0] bytes_zero_to_seven;
	logic [63:0] bytes_eight_to_fifteen;
	logic [15:0] bytes_sixteen_seventeen;

	// Descriptors that have been predicted but have not come back yet, oldest first.
	descriptor_t pending_descriptors[$];
	int unsigned mismatch_count;
	int unsigned cycle_count;

	display_mode_to_detailed_timing i_dut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.start                   (start),
		.busy                    (busy),
		.frame_width             (frame_width),
		.frame_height            (frame_height),
		.refresh_hz              (refresh_hz),
		.done                    (done),
		.descriptor_ok           (descriptor_ok),
		.pixel_clock_units       (pixel_clock_units),
		.bytes_zero_to_seven     (bytes_zero_to_seven),
		.bytes_eight_to_fifteen  (bytes_eight_to_fifteen),
		.bytes_sixteen_seventeen (bytes_sixteen_seventeen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Computes the descriptor for one mode. The blanking and sync widths follow the
	// usual rules for this kind of generator: the horizontal blank is a twentieth of
	// the width rounded up to eight pixels, with a floor of 160. The vertical blank is
	// a twentieth of the height, with a floor of 30. The pixel clock is the whole
	// frame times the refresh rate, rounded to the nearest 10 kHz. Any mode that
	// does not fit the descriptor comes back as an all-zero result with ok low.
	function automatic descriptor_t predict_descriptor(input logic [15:0] w,
			input logic [15:0] h, input logic [9:0] r);
		descriptor_t res;
		logic [31:0] hblank;
		logic [31:0] vblank;
		logic [31:0] hsync;
		logic [31:0] hfront;
		logic [63:0] htotal;
		logic [63:0] vtotal;
		logic [63:0] units;
		logic [7:0]  sync_high_bits;

		res = '0;
		if (w == 16'd0 || h == 16'd0 || r == 10'd0) begin
			return res;
		end
		hblank = ((32'(w) / 20) + 32'd7) & ~32'd7;
		if (hblank < 32'd160) begin
			hblank = 32'd160;
		end
		vblank = 32'(h) / 20;
		if (vblank < 32'd30) begin
			vblank = 32'd30;
		end
		hsync = 32'(w) / 100;
		if (hsync < 32'd32) begin
			hsync = 32'd32;
		end
		hsync = (hsync + 32'd7) & ~32'd7;
		hfront = hblank / 3;
		if (hfront < 32'd48) begin
			hfront = 32'd48;
		end
		hfront = (hfront + 32'd7) & ~32'd7;
		// If the porch and the sync do not fit inside the blank, both fall back to
		// their minimum widths.
		if (hfront + hsync >= hblank) begin
			hfront = 32'd48;
			hsync = 32'd32;
		end

		htotal = 64'(w) + 64'(hblank);
		vtotal = 64'(h) + 64'(vblank);
		units = (htotal * vtotal * 64'(r) + 64'd5000) / 64'd10000;
		if (units == 64'd0 || units > 64'd65535 || w > dmdt_pkg::SIZE_LIMIT ||
				h > dmdt_pkg::SIZE_LIMIT || hblank > 32'(dmdt_pkg::SIZE_LIMIT) ||
				vblank > 32'(dmdt_pkg::SIZE_LIMIT)) begin
			return res;
		end

		sync_high_bits = {hfront[9:8], hsync[9:8], 4'b0000};
		res.ok = 1'b1;
		res.clock_units = units[15:0];
		res.low_bytes = {h[11:8], vblank[11:8], vblank[7:0], h[7:0],
			w[11:8], hblank[11:8], hblank[7:0], w[7:0], units[15:8], units[7:0]};
		res.mid_bytes = {8'h00, 8'h00, 8'h00, 8'h00, sync_high_bits,
			dmdt_pkg::VFRONT, dmdt_pkg::VSYNC, hsync[7:0], hfront[7:0]};
		res.high_bytes = {dmdt_pkg::DTD_FLAGS, 8'h00};
		return res;
	endfunction

	// Mostly zero or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;

		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end else begin
			return $urandom_range(20, 40);
		end
	endfunction

	// Keeps start low for the given number of cycles. The mode fields carry
	// random junk in the meantime, which the block has to ignore.
	task automatic idle_cycles(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			frame_width <= 16'($urandom);
			frame_height <= 16'($urandom);
			refresh_hz <= 10'($urandom);
		end
	endtask

	// Offers one mode at the next falling edge and holds it until a rising edge
	// sees busy low. The prediction goes into the queue right at that edge.
	// start is left high. The next call either keeps it high or idle_cycles
	// lowers it, so each falling edge writes start only once.
	task automatic send_mode(input logic [15:0] w, input logic [15:0] h, input logic [9:0] r);
		@(negedge clk);
		start <= 1'b1;
		frame_width <= w;
		frame_height <= h;
		refresh_hz <= r;
		do begin
			@(posedge clk);
		end while (busy);
		pending_descriptors.push_back(predict_descriptor(w, h, r));
	endtask

	// Holds the sender back until every descriptor that was sent has come back.
	task automatic wait_for_results();
		idle_cycles(1);
		wait (pending_descriptors.size() == 0);
	endtask

	// Covers every way a mode can be rejected: a zero in each field, a size just
	// over the limit, the largest values of all fields, a clock that rounds to
	// zero, and a clock far beyond the largest value that 16 bits can hold.
	task automatic test_rejected_modes();
		send_mode(16'd0, 16'd1080, 10'd60);
		send_mode(16'd1920, 16'd0, 10'd60);
		send_mode(16'd1920, 16'd1080, 10'd0);
		send_mode(16'd0, 16'd0, 10'd0);
		send_mode(16'd4096, 16'd1080, 10'd60);
		send_mode(16'd1920, 16'd4096, 10'd60);
		send_mode(16'hffff, 16'hffff, 10'd1023);
		send_mode(16'd1, 16'd1, 10'd1);
		send_mode(16'd4095, 16'd4095, 10'd1023);
		idle_cycles(pick_gap());
	endtask

	// Sends common video modes back to back, the smallest mode that still gives a
	// clock of one unit, and the largest sizes at a refresh rate that still fits.
	task automatic test_standard_modes();
		send_mode(16'd640, 16'd480, 10'd60);
		send_mode(16'd1280, 16'd720, 10'd60);
		send_mode(16'd1920, 16'd1080, 10'd60);
		send_mode(16'd2560, 16'd1440, 10'd144);
		send_mode(16'd3840, 16'd2160, 10'd30);
		send_mode(16'd1, 16'd1, 10'd2);
		send_mode(16'd4095, 16'd4095, 10'd35);
		send_mode(16'd4095, 16'd1, 10'd1023);
		idle_cycles(pick_gap());
	endtask

	// 3840x2160 at 71 Hz is just under the top of the clock range, and at 72 Hz it
	// is just over it.
	task automatic test_clock_limits();
		send_mode(16'd3840, 16'd2160, 10'd71);
		send_mode(16'd3840, 16'd2160, 10'd72);
		send_mode(16'd1, 16'd4095, 10'd1023);
		idle_cycles(pick_gap());
	endtask

	// Random modes. Most have sizes within the limit and a refresh rate picked so
	// that the clock usually fits, which gives real descriptors with random
	// content. The rest have a random rate at legal sizes, or are fully random
	// fields that also reach the top bits, the zeros and the oversize cases.
	// Some runs of 100 items have no gaps at all. Halfway through, the sender
	// waits until the block has returned every result.
	task automatic test_random_modes(input int unsigned count);
		int unsigned roll;
		int unsigned rate_max;
		int unsigned approx_frame;
		logic [15:0] w;
		logic [15:0] h;
		logic [9:0]  r;
		bit          burst;

		burst = 1'b0;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			if (i == count / 2) begin
				wait_for_results();
			end
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				w = 16'($urandom_range(1, 4095));
				h = 16'($urandom_range(1, 4095));
				// The frame size is a rough upper bound. It keeps the rate
				// mostly within the range where the clock still fits.
				approx_frame = (w + w / 20 + 200) * (h + h / 20 + 40);
				rate_max = 655000000 / approx_frame;
				if (rate_max > 1023) begin
					rate_max = 1023;
				end
				if (rate_max < 1) begin
					rate_max = 1;
				end
				r = 10'($urandom_range(1, rate_max));
			end else if (roll < 85) begin
				w = 16'($urandom_range(1, 4095));
				h = 16'($urandom_range(1, 4095));
				r = 10'($urandom_range(0, 1023));
			end else begin
				w = 16'($urandom);
				h = 16'($urandom);
				r = 10'($urandom);
			end
			send_mode(w, h, r);
			if (!burst) begin
				idle_cycles(pick_gap());
			end
		end
		idle_cycles(1);
	endtask

	// Takes every result in the cycle that done marks and compares it with the
	// oldest prediction. The outputs are read in the active region right after
	// the edge, so these are the values from before the edge.
	always @(posedge clk) begin
		descriptor_t seen;
		descriptor_t want;

		if (arst_n && done) begin
			seen = {descriptor_ok, pixel_clock_units, bytes_zero_to_seven,
				bytes_eight_to_fifteen, bytes_sixteen_seventeen};
			if (pending_descriptors.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, seen);
				mismatch_count++;
			end else begin
				want = pending_descriptors.pop_front();
				if (seen.ok !== want.ok) begin
					$display("%0t: descriptor_ok expected %0h actual %0h",
						$time, want.ok, seen.ok);
					mismatch_count++;
				end
				if (seen.clock_units !== want.clock_units) begin
					$display("%0t: pixel_clock_units expected %0h actual %0h",
						$time, want.clock_units, seen.clock_units);
					mismatch_count++;
				end
				if (seen.low_bytes !== want.low_bytes) begin
					$display("%0t: bytes_zero_to_seven expected %h actual %h",
						$time, want.low_bytes, seen.low_bytes);
					mismatch_count++;
				end
				if (seen.mid_bytes !== want.mid_bytes) begin
					$display("%0t: bytes_eight_to_fifteen expected %h actual %h",
						$time, want.mid_bytes, seen.mid_bytes);
					mismatch_count++;
				end
				if (seen.high_bytes !== want.high_bytes) begin
					$display("%0t: bytes_sixteen_seventeen expected %h actual %h",
						$time, want.high_bytes, seen.high_bytes);
					mismatch_count++;
				end
			end
		end
	end

	// Stops a hung run. The limit is far above the slowest correct run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		frame_width = 16'd0;
		frame_height = 16'd0;
		refresh_hz = 10'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_cycles(2);

		test_rejected_modes();
		test_standard_modes();
		test_clock_limits();
		wait_for_results();
		test_random_modes(RANDOM_ITEMS);

		// All items are in. Wait for the last results, then wait out DRAIN_CYCLES, in
		// which an extra result would be caught.
		wait (pending_descriptors.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dmdt_pkg.sv
src/display_mode_to_detailed_timing.sv
src/dmdt_checker.sv
tb/sv/tb.sv
